### design/cpbf_pkg.sv
// Shared types and constants for the brute-force closest pair block.
package cpbf_pkg;

  localparam int DEF_MAX_POINTS  = 256;
  localparam int DEF_COORD_BITS  = 16;
  localparam int FIELD_W         = 16;
  localparam int OUT_IDX_W       = 8;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROW,
    ST_COL,
    ST_DRAIN
  } cpbf_state_t;

  // Control for the distance datapath, aligned with the store read data.
  typedef struct packed {
    logic clear;
    logic load_row;
    logic pair;
  } cpbf_ctl_t;

endpackage

### design/closest_pair_brute_force.sv
// Top level of the brute-force closest pair block: loader, scan sequencer and result register.
// A point item is taken whenever the block is loading; items that are not marked last stream in back to back.
// The last item of a set of n points starts a scan of n-1 row reads plus n(n-1)/2 pair reads
// through the single read port of the point store, then a drain of the distance pipeline.
// The result item is registered and may wait for the sink while the next set loads.
// Reset (rst, synchronous) clears the control state; the point store is not cleared.
module closest_pair_brute_force import cpbf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FIELD_W-1:0]   coord_x,
  input  logic [FIELD_W-1:0]   coord_y,
  input  logic                 last_point,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] first_index,
  output logic [OUT_IDX_W-1:0] second_index,
  output logic                 found
);

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int PW   = 2 * COORD_BITS;

  cpbf_state_t state, state_next;

  logic [CNTW-1:0] count, count_next, count_loaded;
  logic [IW-1:0]   row, row_next, col, col_next;
  logic            in_acc, store_ok;
  logic            clear_now, issue_row, issue_pair, out_load, out_free, pipe_empty;
  logic [IW-1:0]   rd_addr;

  // Read-side control, registered so it lines up with the store read data.
  logic            rd_row_v, rd_pair_v;
  logic [IW-1:0]   rd_row, rd_col;
  logic [PW-1:0]   rd_data;

  logic [COORD_BITS+FIELD_W-1:0] x_ext, y_ext;
  logic [PW-1:0]                 wr_data;

  cpbf_ctl_t     dist_ctl;
  logic          dist_busy, dist_found;
  logic [IW-1:0] best_first, best_second;
  logic [IW+OUT_IDX_W-1:0] first_ext, second_ext;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign store_ok = (count < CNTW'(MAX_POINTS));

  // Each coordinate is the low COORD_BITS bits of its field, read as two's complement.
  assign x_ext   = {{COORD_BITS{1'b0}}, coord_x};
  assign y_ext   = {{COORD_BITS{1'b0}}, coord_y};
  assign wr_data = {x_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0]};

  cpbf_store #(
    .DEPTH (MAX_POINTS),
    .AW    (IW),
    .DW    (PW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && store_ok),
    .wr_addr (count[IW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign count_loaded = store_ok ? count + CNTW'(1) : count;
  assign out_free     = !out_valid || !out_stall;
  assign pipe_empty   = !rd_row_v && !rd_pair_v && !dist_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
    col <= col_next;
  end

  // Sequencer: one row read to fetch point i, then one pair read per column j > i.
  always_comb begin
    state_next = state;
    count_next = count;
    row_next   = row;
    col_next   = col;
    clear_now  = 1'b0;
    issue_row  = 1'b0;
    issue_pair = 1'b0;
    out_load   = 1'b0;
    rd_addr    = row;
    unique case (state)
      ST_LOAD: begin
        if (in_acc) begin
          count_next = count_loaded;
          if (last_point) begin
            clear_now = 1'b1;
            row_next  = '0;
            if (count_loaded < CNTW'(2)) begin
              state_next = ST_DRAIN;
            end else begin
              state_next = ST_ROW;
            end
          end
        end
      end
      ST_ROW: begin
        rd_addr    = row;
        issue_row  = 1'b1;
        col_next   = row + IW'(1);
        state_next = ST_COL;
      end
      ST_COL: begin
        rd_addr    = col;
        issue_pair = 1'b1;
        if (CNTW'(col) + CNTW'(1) == count) begin
          if (CNTW'(row) + CNTW'(2) == count) begin
            state_next = ST_DRAIN;
          end else begin
            row_next   = row + IW'(1);
            state_next = ST_ROW;
          end
        end else begin
          col_next = col + IW'(1);
        end
      end
      ST_DRAIN: begin
        // Wait until the last pair has updated the best, and the result slot is free.
        if (pipe_empty && out_free) begin
          out_load   = 1'b1;
          count_next = '0;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_row_v  <= 1'b0;
      rd_pair_v <= 1'b0;
    end else begin
      rd_row_v  <= issue_row;
      rd_pair_v <= issue_pair;
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= row;
    rd_col <= col;
  end

  assign dist_ctl = '{clear: clear_now, load_row: rd_row_v, pair: rd_pair_v};

  cpbf_dist #(
    .CB (COORD_BITS),
    .IW (IW)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .ctl         (dist_ctl),
    .rd_data     (rd_data),
    .row_idx     (rd_row),
    .col_idx     (rd_col),
    .busy        (dist_busy),
    .found       (dist_found),
    .best_first  (best_first),
    .best_second (best_second)
  );

  // Indices are reported in their low eight bits; no pair reports zeros.
  assign first_ext  = {{OUT_IDX_W{1'b0}}, best_first};
  assign second_ext = {{OUT_IDX_W{1'b0}}, best_second};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found        <= dist_found;
      first_index  <= dist_found ? first_ext[OUT_IDX_W-1:0] : '0;
      second_index <= dist_found ? second_ext[OUT_IDX_W-1:0] : '0;
    end
  end

endmodule

### design/cpbf_store.sv
// Point store: one write port and one registered read port.
module cpbf_store import cpbf_pkg::*; #(
  parameter int DEPTH = DEF_MAX_POINTS,
  parameter int AW    = 8,
  parameter int DW    = 2 * DEF_COORD_BITS
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### design/cpbf_dist.sv
// Pair distance pipeline: absolute differences, squares, then sum and best-pair update.
module cpbf_dist import cpbf_pkg::*; #(
  parameter int CB = DEF_COORD_BITS,
  parameter int IW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  cpbf_ctl_t       ctl,
  input  logic [2*CB-1:0] rd_data,
  input  logic [IW-1:0]   row_idx,
  input  logic [IW-1:0]   col_idx,
  output logic            busy,
  output logic            found,
  output logic [IW-1:0]   best_first,
  output logic [IW-1:0]   best_second
);

  localparam int DW = 2 * CB + 2;

  logic signed [CB-1:0] pi_x, pi_y;
  logic signed [CB:0]   ax, ay, bx, by;
  logic [CB:0]          dx, dy;
  logic                 v1, v2;
  logic [IW-1:0]        i1, j1, i2, j2;
  logic [DW-1:0]        sx, sy, dsum, best_d;

  assign ax = {pi_x[CB-1], pi_x};
  assign ay = {pi_y[CB-1], pi_y};
  assign bx = {rd_data[2*CB-1], rd_data[2*CB-1:CB]};
  assign by = {rd_data[CB-1], rd_data[CB-1:0]};

  always_ff @(posedge clk) begin
    if (ctl.load_row) begin
      pi_x <= rd_data[2*CB-1:CB];
      pi_y <= rd_data[CB-1:0];
    end
    dx <= (ax >= bx) ? unsigned'(ax - bx) : unsigned'(bx - ax);
    dy <= (ay >= by) ? unsigned'(ay - by) : unsigned'(by - ay);
    i1 <= row_idx;
    j1 <= col_idx;
    sx <= dx * dx;
    sy <= dy * dy;
    i2 <= i1;
    j2 <= j1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.pair;
      v2 <= v1;
    end
  end

  assign dsum = sx + sy;

  // Coincident points are skipped; the first strictly smaller distance wins.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (v2 && (dsum != '0) && (!found || dsum < best_d)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && (dsum != '0) && (!found || dsum < best_d)) begin
      best_d      <= dsum;
      best_first  <= i2;
      best_second <= j2;
    end
  end

  assign busy = v1 || v2;

endmodule

### design/cpbf_check.sv
// Port-level checks for the closest pair block, bound to the top level.
module cpbf_check import cpbf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 last_point,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [OUT_IDX_W-1:0] first_index,
  input logic [OUT_IDX_W-1:0] second_index,
  input logic                 found
);

  // A waiting result item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(first_index)
      && $stable(second_index) && $stable(found))
    else $error("result item changed while stalled");

  // Without a pair both indices read as zero.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> first_index == '0 && second_index == '0)
    else $error("indices nonzero on a result without a pair");

  // Once the last item of a set is taken, input stalls while the scan runs.
  a_scan_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_point |=> in_stall)
    else $error("input taken right after the last item");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind closest_pair_brute_force cpbf_check u_cpbf_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last_point   (last_point),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .first_index  (first_index),
  .second_index (second_index),
  .found        (found)
);

### sim/tb_top.sv
// Self-checking testbench for the brute-force closest pair block.
module tb_top;
  import cpbf_pkg::*;

  // The predictor stores as many points as the block does, and every coordinate uses the
  // full field because the coordinate width equals the field width in this build.
  localparam int STORE_DEPTH  = DEF_MAX_POINTS;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_WAIT     = 6;
  localparam int RANDOM_ITEMS = 1030;

  // One expected result item: the pair indices and the found flag.
  typedef struct packed {
    logic [OUT_IDX_W-1:0] first;
    logic [OUT_IDX_W-1:0] second;
    logic                 found;
  } pair_result_t;

  // How the coordinates of a random set are drawn.
  typedef enum int {
    COORD_FULL,
    COORD_NARROW,
    COORD_EDGE,
    COORD_CLUSTER,
    COORD_MIXED
  } coord_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FIELD_W-1:0]   coord_x = '0;
  logic [FIELD_W-1:0]   coord_y = '0;
  logic                 last_point = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_IDX_W-1:0] first_index;
  logic [OUT_IDX_W-1:0] second_index;
  logic                 found;

  // Predictor state: the points of the set being loaded, in load order.
  logic signed [FIELD_W-1:0] stored_x [STORE_DEPTH];
  logic signed [FIELD_W-1:0] stored_y [STORE_DEPTH];
  int unsigned               stored_count = 0;
  pair_result_t              pending_pairs [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  // While quiet_mode is set neither side idles, which gives back-to-back stretches.
  bit  quiet_mode     = 1'b0;
  int  stall_left     = 0;
  bit  stall_armed    = 1'b0;

  closest_pair_brute_force uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_index  (first_index),
    .second_index (second_index),
    .found        (found)
  );

  always #10 clk = ~clk;

  // Scan every pair i<j of the stored set in load order. Coincident pairs are skipped,
  // and a later pair only wins with a strictly smaller squared distance, so ties go to
  // the pair met first. With no pair at nonzero distance the result is all zeros.
  function automatic pair_result_t closest_stored_pair();
    pair_result_t      best_pair;
    longint unsigned   best_dist;
    longint unsigned   pair_dist;
    longint            dx;
    longint            dy;
    best_pair = '0;
    best_dist = '0;
    for (int i = 0; i < int'(stored_count); i++) begin
      for (int j = i + 1; j < int'(stored_count); j++) begin
        dx = longint'(stored_x[i]) - longint'(stored_x[j]);
        dy = longint'(stored_y[i]) - longint'(stored_y[j]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        // Differences stay below 2^17, so the sum cannot saturate 64 bits.
        pair_dist = longint'(dx * dx) + longint'(dy * dy);
        if (pair_dist != 0 && (!best_pair.found || pair_dist < best_dist)) begin
          best_pair.found  = 1'b1;
          best_pair.first  = OUT_IDX_W'(i);
          best_pair.second = OUT_IDX_W'(j);
          best_dist        = pair_dist;
        end
      end
    end
    return best_pair;
  endfunction

  // Send one point item. The sender idles a drawn number of cycles first; with no idle
  // cycles valid simply stays high from the previous item. Once the item is taken the
  // predictor stores it, and a last item yields the expected result and empties the set.
  task automatic send_point(input logic signed [FIELD_W-1:0] x,
                            input logic signed [FIELD_W-1:0] y,
                            input logic last);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    coord_x    <= x;
    coord_y    <= y;
    last_point <= last;
    do @(posedge clk); while (in_stall);
    // A point that finds the store full is dropped, but a last one still ends the set.
    if (stored_count < STORE_DEPTH) begin
      stored_x[stored_count] = x;
      stored_y[stored_count] = y;
      stored_count++;
    end
    if (last) begin
      pending_pairs.insert(pending_pairs.size(), closest_stored_pair());
      stored_count = 0;
    end
  endtask

  // Draw one coordinate. Narrow and cluster modes make coincident points and equal
  // distances common; edge mode sticks to the ends of the signed range and to values around zero.
  function automatic logic signed [FIELD_W-1:0] draw_coord(input coord_mode_t mode,
                                                           input logic [FIELD_W-1:0] base);
    coord_mode_t pick;
    pick = mode;
    if (mode == COORD_MIXED) pick = coord_mode_t'($urandom_range(0, 3));
    case (pick)
      COORD_NARROW:  return FIELD_W'(int'($urandom_range(0, 6)) - 3);
      COORD_CLUSTER: return base + FIELD_W'(int'($urandom_range(0, 16)) - 8);
      COORD_EDGE: begin
        case ($urandom_range(0, 5))
          0:       return 16'sh8000;
          1:       return 16'sh8001;
          2:       return 16'shFFFF;
          3:       return 16'sh0000;
          4:       return 16'sh7FFE;
          default: return 16'sh7FFF;
        endcase
      end
      default:       return FIELD_W'($urandom());
    endcase
  endfunction

  // Sets without any pair at nonzero distance: one point, and coincident points only.
  task automatic test_small_sets();
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd123, -16'sd45, 1'b0);
    send_point(16'sd123, -16'sd45, 1'b1);
    send_point(-16'sd7, 16'sd9, 1'b0);
    send_point(-16'sd7, 16'sd9, 1'b0);
    send_point(-16'sd7, 16'sd9, 1'b1);
  endtask

  // Coordinates at both ends of the signed range, giving the largest squared distances.
  task automatic test_extremes();
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
  endtask

  // Equal distances go to the earliest pair, a coincident pair does not win, and the best
  // pair can be the very last one scanned.
  task automatic test_ties();
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd0, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd7, 16'sd5, 1'b1);
    send_point(16'sh8000, 16'sd0, 1'b0);
    send_point(16'sh7FFF, 16'sd0, 1'b0);
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(16'sd101, 16'sd100, 1'b1);
  endtask

  // A set that exactly fills the store, then one that overflows it. The overflow points
  // sit right next to the first point, so storing any of them would change the answer.
  task automatic test_store_full();
    logic signed [FIELD_W-1:0] x0;
    logic signed [FIELD_W-1:0] y0;
    for (int n = 0; n < STORE_DEPTH; n++)
      send_point(draw_coord(COORD_FULL, '0), draw_coord(COORD_FULL, '0), n == STORE_DEPTH - 1);
    x0 = draw_coord(COORD_FULL, '0);
    y0 = draw_coord(COORD_FULL, '0);
    send_point(x0, y0, 1'b0);
    for (int n = 1; n < STORE_DEPTH; n++)
      send_point(draw_coord(COORD_FULL, '0), draw_coord(COORD_FULL, '0), 1'b0);
    send_point(x0 + 16'sd1, y0, 1'b0);
    send_point(x0, y0 + 16'sd1, 1'b0);
    send_point(x0 + 16'sd1, y0 + 16'sd1, 1'b1);
  endtask

  // Random sets, mostly small so that scans stay short, with a rare set near capacity.
  task automatic test_random_sets();
    int                 items;
    int                 set_size;
    int                 roll;
    coord_mode_t        mode;
    logic [FIELD_W-1:0] base_x;
    logic [FIELD_W-1:0] base_y;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)       set_size = 1;
      else if (roll < 75) set_size = $urandom_range(2, 12);
      else if (roll < 98) set_size = $urandom_range(13, 40);
      else                set_size = $urandom_range(150, STORE_DEPTH + 3);
      mode       = coord_mode_t'($urandom_range(0, 4));
      base_x     = $urandom();
      base_y     = $urandom();
      quiet_mode = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < set_size; n++)
        send_point(draw_coord(mode, base_x), draw_coord(mode, base_y), n == set_size - 1);
      items += set_size;
    end
    quiet_mode = 1'b0;
  endtask

  // Result side. While no result is offered the stall toggles at random; for each offered
  // result a number of stall cycles is drawn once and then counted down.
  always @(negedge clk) begin
    if (!out_valid) begin
      stall_armed = 1'b0;
      out_stall <= !quiet_mode && ($urandom_range(0, 3) == 0);
    end else begin
      if (!stall_armed) begin
        stall_left  = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
        stall_armed = 1'b1;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every taken result is compared with the oldest expected one.
  always @(posedge clk) begin : result_check
    pair_result_t want;
    if (!rst && out_valid && !out_stall) begin
      stall_armed = 1'b0;
      if (pending_pairs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: first=%0d second=%0d found=%0b",
                   $time, first_index, second_index, found);
      end else begin
        want = pending_pairs.pop_front();
        if (first_index !== want.first || second_index !== want.second ||
            found !== want.found) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"[%0t] mismatch: expected first=%0d second=%0d found=%0b,",
                      " got first=%0d second=%0d found=%0b"},
                     $time, want.first, want.second, want.found,
                     first_index, second_index, found);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pairs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_small_sets();
    test_extremes();
    test_ties();
    test_store_full();
    test_random_sets();

    @(negedge clk);
    in_valid <= 1'b0;
    // Wait for the last scan to finish, then give any stray result time to show up.
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
